// ===== hw/rtl/prfd_pkg.sv =====
package prfd_pkg;

  localparam int ANGLE_DIGITS  = 3;
  localparam int RADIUS_DIGITS = 4;

  localparam int POS_W = 3;
  localparam logic [POS_W-1:0] ANGLE_END = POS_W'(ANGLE_DIGITS);
  localparam logic [POS_W-1:0] FRAME_LEN = POS_W'(ANGLE_DIGITS + RADIUS_DIGITS);

  localparam int BYTE_W   = 8;
  localparam int ANGLE_W  = 10;
  localparam int DEG_W    = 9;
  localparam int RADIUS_W = 14;
  localparam int IDX_W    = 7;
  localparam int MAG_W    = 25;
  localparam int OUT_W    = 15;
  localparam int FRAC_W   = 24;
  localparam int PROD_W   = RADIUS_W + MAG_W;

  localparam logic [BYTE_W-1:0] START_CHAR_RST = 8'd35;
  localparam logic [BYTE_W-1:0] CHAR_ZERO      = 8'h30;
  localparam logic [BYTE_W-1:0] CHAR_NINE      = 8'h39;

  localparam logic [DEG_W-1:0] DEG_90  = 9'd90;
  localparam logic [DEG_W-1:0] DEG_180 = 9'd180;
  localparam logic [DEG_W-1:0] DEG_360 = 9'd360;

  localparam int CFG_ADDR_W = 3;
  localparam logic [CFG_ADDR_W-1:0] REG_START_CHAR = 3'd0;

  // pi/180 in Q30
  localparam logic [63:0] DEG_TO_RAD_Q30 = 64'd18740330;

  typedef struct packed {
    logic [DEG_W-1:0]    angle;
    logic [RADIUS_W-1:0] radius;
  } polar_t;

  typedef struct packed {
    logic [MAG_W-1:0]    mag_sin;
    logic [MAG_W-1:0]    mag_cos;
    logic                neg_sin;
    logic                neg_cos;
    logic [RADIUS_W-1:0] radius;
  } trig_t;

  typedef logic [90:0][MAG_W-1:0] sin_tab_t;

  // Taylor series through x^15, truncating at every step, Q24 result
  function automatic logic [MAG_W-1:0] sin_quarter_q24(input logic [IDX_W-1:0] d);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [63:0]        s;
    x    = 64'(d) * DEG_TO_RAD_Q30;
    x2   = (x * x) >> 30;
    term = x;
    sum  = signed'(x);
    term = ((term * x2) >> 30) / 64'd6;
    sum  = sum - signed'(term);
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + signed'(term);
    term = ((term * x2) >> 30) / 64'd42;
    sum  = sum - signed'(term);
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + signed'(term);
    term = ((term * x2) >> 30) / 64'd110;
    sum  = sum - signed'(term);
    term = ((term * x2) >> 30) / 64'd156;
    sum  = sum + signed'(term);
    term = ((term * x2) >> 30) / 64'd210;
    sum  = sum - signed'(term);
    if (sum < 0) begin
      sum = 64'sd0;
    end
    s = (unsigned'(sum) + 64'd32) >> 6;
    if (s > 64'd16777216) begin
      s = 64'd16777216;
    end
    return MAG_W'(s);
  endfunction

  function automatic sin_tab_t build_sin_tab();
    sin_tab_t tab;
    for (int d = 0; d <= 90; d++) begin
      tab[d] = sin_quarter_q24(IDX_W'(d));
    end
    return tab;
  endfunction

  localparam sin_tab_t SIN_TAB = build_sin_tab();

endpackage

// ===== hw/rtl/prfd_parser.sv =====
module prfd_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [7:0]          start_char,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          rx_byte,
  output logic                frm_valid,
  input  logic                frm_ready,
  output prfd_pkg::polar_t    frm_data
);
  import prfd_pkg::*;

  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic                open_r, open_nxt;
  logic [ANGLE_W-1:0]  angle_r, angle_nxt;
  logic [RADIUS_W-1:0] radius_r, radius_nxt;
  logic                ended_r, ended_nxt;
  logic                valid_r, valid_nxt;
  polar_t              data_r, data_nxt;

  logic                fire;
  logic                is_digit;
  logic [3:0]          digit;
  logic [ANGLE_W-1:0]  angle_mod;

  assign in_ready  = !valid_r || frm_ready;
  assign fire      = in_valid && in_ready;
  assign is_digit  = rx_byte inside {[CHAR_ZERO:CHAR_NINE]};
  assign digit     = 4'(rx_byte - CHAR_ZERO);
  assign frm_valid = valid_r;
  assign frm_data  = data_r;

  // the last byte of a frame is a radius byte, so the angle is already final;
  // angle_r stays below 1024, so at most two subtractions of 360
  always_comb begin
    if (angle_r >= 10'd720) begin
      angle_mod = angle_r - 10'd720;
    end else if (angle_r >= 10'd360) begin
      angle_mod = angle_r - 10'd360;
    end else begin
      angle_mod = angle_r;
    end
  end

  always_comb begin
    pos_nxt    = pos_r;
    open_nxt   = open_r;
    angle_nxt  = angle_r;
    radius_nxt = radius_r;
    ended_nxt  = ended_r;
    valid_nxt  = in_ready ? 1'b0 : valid_r;
    data_nxt   = data_r;
    if (fire) begin
      if (rx_byte == start_char) begin
        open_nxt   = 1'b1;
        pos_nxt    = '0;
        angle_nxt  = '0;
        radius_nxt = '0;
        ended_nxt  = 1'b0;
      end else if (open_r) begin
        // radius field starts fresh
        if (pos_r == ANGLE_END) begin
          ended_nxt = 1'b0;
        end
        if (!ended_nxt && is_digit) begin
          if (pos_r < ANGLE_END) begin
            angle_nxt = ANGLE_W'(angle_r * 10'd10 + ANGLE_W'(digit));
          end else begin
            radius_nxt = RADIUS_W'(radius_r * 14'd10 + RADIUS_W'(digit));
          end
        end else begin
          ended_nxt = 1'b1;
        end
        pos_nxt = pos_r + 1'b1;
        if (pos_nxt == FRAME_LEN) begin
          valid_nxt       = 1'b1;
          data_nxt.angle  = DEG_W'(angle_mod);
          data_nxt.radius = radius_nxt;
          open_nxt        = 1'b0;
          pos_nxt         = '0;
          ended_nxt       = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      open_r   <= 1'b0;
      angle_r  <= '0;
      radius_r <= '0;
      ended_r  <= 1'b0;
      valid_r  <= 1'b0;
    end else begin
      pos_r    <= pos_nxt;
      open_r   <= open_nxt;
      angle_r  <= angle_nxt;
      radius_r <= radius_nxt;
      ended_r  <= ended_nxt;
      valid_r  <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

// ===== hw/rtl/prfd_lookup.sv =====
module prfd_lookup (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             frm_valid,
  output logic             frm_ready,
  input  prfd_pkg::polar_t frm_data,
  output logic             trig_valid,
  input  logic             trig_ready,
  output prfd_pkg::trig_t  trig_data
);
  import prfd_pkg::*;

  logic             valid_r, valid_nxt;
  trig_t            data_r, data_nxt;
  logic [DEG_W-1:0] cos_angle;
  logic [DEG_W-1:0] half_sin, half_cos;
  logic [IDX_W-1:0] idx_sin, idx_cos;

  assign frm_ready  = !valid_r || trig_ready;
  assign trig_valid = valid_r;
  assign trig_data  = data_r;

  always_comb begin
    cos_angle = frm_data.angle + DEG_90;
    if (cos_angle >= DEG_360) begin
      cos_angle = cos_angle - DEG_360;
    end
    half_sin = (frm_data.angle >= DEG_180) ? frm_data.angle - DEG_180 : frm_data.angle;
    half_cos = (cos_angle >= DEG_180) ? cos_angle - DEG_180 : cos_angle;
    // fold into the first quadrant
    idx_sin  = IDX_W'((half_sin <= DEG_90) ? half_sin : DEG_180 - half_sin);
    idx_cos  = IDX_W'((half_cos <= DEG_90) ? half_cos : DEG_180 - half_cos);

    data_nxt         = data_r;
    valid_nxt        = frm_ready ? frm_valid : valid_r;
    if (frm_ready) begin
      data_nxt.mag_sin = SIN_TAB[idx_sin];
      data_nxt.mag_cos = SIN_TAB[idx_cos];
      data_nxt.neg_sin = frm_data.angle >= DEG_180;
      data_nxt.neg_cos = cos_angle >= DEG_180;
      data_nxt.radius  = frm_data.radius;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

// ===== hw/rtl/prfd_scale.sv =====
module prfd_scale (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   trig_valid,
  output logic                   trig_ready,
  input  prfd_pkg::trig_t        trig_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic signed [14:0]     out_speed_milli,
  output logic signed [14:0]     out_turn_milli
);
  import prfd_pkg::*;

  localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FRAC_W - 1);

  logic                valid_r, valid_nxt;
  logic [OUT_W-1:0]    speed_r, speed_nxt;
  logic [OUT_W-1:0]    turn_r, turn_nxt;
  logic [PROD_W-1:0]   prod_sin, prod_cos;
  logic [RADIUS_W-1:0] rnd_sin, rnd_cos;

  assign trig_ready      = !valid_r || out_ready;
  assign out_valid       = valid_r;
  assign out_speed_milli = signed'(speed_r);
  assign out_turn_milli  = signed'(turn_r);

  always_comb begin
    prod_sin = PROD_W'(trig_data.radius) * PROD_W'(trig_data.mag_sin) + ROUND_HALF;
    prod_cos = PROD_W'(trig_data.radius) * PROD_W'(trig_data.mag_cos) + ROUND_HALF;
    rnd_sin  = RADIUS_W'(prod_sin >> FRAC_W);
    rnd_cos  = RADIUS_W'(prod_cos >> FRAC_W);

    valid_nxt = trig_ready ? trig_valid : valid_r;
    speed_nxt = speed_r;
    turn_nxt  = turn_r;
    if (trig_ready) begin
      // apply sign after rounding
      speed_nxt = trig_data.neg_sin ? OUT_W'(OUT_W'(0) - OUT_W'(rnd_sin)) : OUT_W'(rnd_sin);
      turn_nxt  = trig_data.neg_cos ? OUT_W'(OUT_W'(0) - OUT_W'(rnd_cos)) : OUT_W'(rnd_cos);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    speed_r <= speed_nxt;
    turn_r  <= turn_nxt;
  end

endmodule

// ===== hw/rtl/polar_remote_frame_decoder_top.sv =====
// Polar remote frame decoder.
// Input channel (in_valid/in_ready/in_rx_byte) takes one received byte per item.
// A byte equal to the start_char register opens or restarts a frame; the next three
// bytes are angle digits and the following four radius digits. The seventh data byte
// produces one result item on the out_ channel: out_speed_milli = r*sin(angle) and
// out_turn_milli = r*cos(angle), rounded, two's complement. Other bytes give no result.
// Throughput: one byte per cycle while out_ready is high. A result passes through the
// parser register, the sine table register and the multiply and round register, in
// that order.
// Configuration: APB-style port, start_char at byte address 0; writes are taken at
// psel & penable & pwrite, pready is tied high, reads return the register (zero elsewhere).
// Reset (rst_n low, synchronous) sets start_char to '#' and closes any open frame.
// When out_ready is low the pipeline holds; in_ready drops only once the register
// behind the parser is full and cannot advance, so no item is lost.
module polar_remote_frame_decoder_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_rx_byte,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [14:0]  out_speed_milli,
  output logic signed [14:0]  out_turn_milli,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [2:0]          cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready
);
  import prfd_pkg::*;

  logic [BYTE_W-1:0] start_char_r, start_char_nxt;
  logic              frm_valid, frm_ready;
  polar_t            frm_data;
  logic              trig_valid, trig_ready;
  trig_t             trig_data;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == REG_START_CHAR) ? 32'(start_char_r) : 32'd0;

  always_comb begin
    start_char_nxt = start_char_r;
    if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
        && cfg_paddr == REG_START_CHAR) begin
      start_char_nxt = cfg_pwdata[BYTE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_char_r <= START_CHAR_RST;
    end else begin
      start_char_r <= start_char_nxt;
    end
  end

  prfd_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .start_char (start_char_r),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .rx_byte    (in_rx_byte),
    .frm_valid  (frm_valid),
    .frm_ready  (frm_ready),
    .frm_data   (frm_data)
  );

  prfd_lookup u_lookup (
    .clk        (clk),
    .rst_n      (rst_n),
    .frm_valid  (frm_valid),
    .frm_ready  (frm_ready),
    .frm_data   (frm_data),
    .trig_valid (trig_valid),
    .trig_ready (trig_ready),
    .trig_data  (trig_data)
  );

  prfd_scale u_scale (
    .clk             (clk),
    .rst_n           (rst_n),
    .trig_valid      (trig_valid),
    .trig_ready      (trig_ready),
    .trig_data       (trig_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_speed_milli (out_speed_milli),
    .out_turn_milli  (out_turn_milli)
  );

endmodule
